[rtl/hcb_pkg.sv]
`timescale 1ns / 1ps
package hcb_pkg;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 7;
    localparam int WEIGHT_W = 32;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DECODE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MIDCODE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTREE  = 2'd2;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_CLR_CNT,
        OP_ACCEPT,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_ENC_RD,
        OP_RES_CODE,
        OP_RES_ST0,
        OP_RES_ST2,
        OP_RES_END,
        OP_DEC_RD1,
        OP_DEC_RD2,
        OP_DEC_LEAF,
        OP_DEC_STEP,
        OP_EMIT,
        OP_CLR_CODE,
        OP_SCAN_RD,
        OP_LEAF,
        OP_SCAN_INC,
        OP_BUILD_EMPTY,
        OP_INS_RD,
        OP_INS_STEP,
        OP_LINK1,
        OP_LINK2,
        OP_M_START,
        OP_M_B,
        OP_M_SUM,
        OP_A_INIT,
        OP_A_RD,
        OP_A_LEAF,
        OP_A_LEFT,
        OP_A_RIGHT,
        OP_A_DEC,
        OP_A_DONE
    } hcb_op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              byte_ok;
        logic              built;
        logic              root_leaf;
        logic              idx_last;
        logic              cnt_use;
        logic              cur_nil;
        logic              nxt_nil;
        logic              wgt_lt;
        logic              used_zero;
        logic              info_leaf;
        logic              out_free;
    } hcb_stat_t;

endpackage

[rtl/hcb_in_if.sv]
`timescale 1ns / 1ps
interface hcb_in_if;
    import hcb_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] byte_value;
    logic              code_bit;

    modport source (output valid, output kind, output byte_value, output code_bit,
                    input ready);
    modport sink (input valid, input kind, input byte_value, input code_bit,
                  output ready);
endinterface

[rtl/hcb_out_if.sv]
`timescale 1ns / 1ps
interface hcb_out_if;
    import hcb_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   symbol;
    logic                symbol_valid;
    logic [WORD_W-1:0]   code_word;
    logic [LEN_W-1:0]    code_length;

    modport source (output valid, output status, output symbol, output symbol_valid,
                    output code_word, output code_length, input ready);
    modport sink (input valid, input status, input symbol, input symbol_valid,
                  input code_word, input code_length, output ready);
endinterface

[rtl/hcb_ram.sv]
`timescale 1ns / 1ps
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/hcb_ctrl.sv]
`timescale 1ns / 1ps
module hcb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  hcb_pkg::hcb_stat_t st,
    output logic               item_ready,
    output hcb_pkg::hcb_op_t   op
);
    import hcb_pkg::*;

    typedef enum logic [24:0] {
        S_CLEAR    = 25'h0000001,
        S_IDLE     = 25'h0000002,
        S_DISPATCH = 25'h0000004,
        S_CNT_WR   = 25'h0000008,
        S_ENC_WAIT = 25'h0000010,
        S_DEC_RD2  = 25'h0000020,
        S_DEC_CHK  = 25'h0000040,
        S_EMIT     = 25'h0000080,
        S_B_CLR    = 25'h0000100,
        S_SCAN_RD  = 25'h0000200,
        S_SCAN_CHK = 25'h0000400,
        S_SCAN_NXT = 25'h0000800,
        S_SCAN_END = 25'h0001000,
        S_INS_RD   = 25'h0002000,
        S_INS_CMP  = 25'h0004000,
        S_LINK1    = 25'h0008000,
        S_LINK2    = 25'h0010000,
        S_M_START  = 25'h0020000,
        S_M_B      = 25'h0040000,
        S_M_SUM    = 25'h0080000,
        S_A_INIT   = 25'h0100000,
        S_A_RD     = 25'h0200000,
        S_A_PROC   = 25'h0400000,
        S_A_RIGHT  = 25'h0800000,
        S_A_NEXT   = 25'h1000000
    } state_t;

    state_t state_reg, state_next;
    logic   merge_reg, merge_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            merge_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            merge_reg <= merge_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        merge_next = merge_reg;
        op         = OP_NONE;
        item_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLR_CNT;
                if (st.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (st.kind)
                    KIND_COUNT:
                    begin
                        if (st.byte_ok)
                        begin
                            op         = OP_CNT_RD;
                            state_next = S_CNT_WR;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_BUILD:
                    begin
                        state_next = S_B_CLR;
                    end
                    KIND_ENCODE:
                    begin
                        if (!st.built)
                        begin
                            op         = OP_RES_ST2;
                            state_next = S_EMIT;
                        end
                        else if (!st.byte_ok)
                        begin
                            op         = OP_RES_ST0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            op         = OP_ENC_RD;
                            state_next = S_ENC_WAIT;
                        end
                    end
                    KIND_DECODE:
                    begin
                        if (!st.built)
                        begin
                            op         = OP_RES_ST2;
                            state_next = S_EMIT;
                        end
                        else if (st.root_leaf)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            op         = OP_DEC_RD1;
                            state_next = S_DEC_RD2;
                        end
                    end
                    KIND_END:
                    begin
                        op         = OP_RES_END;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CNT_WR:
            begin
                op         = OP_CNT_WR;
                state_next = S_IDLE;
            end
            S_ENC_WAIT:
            begin
                op         = OP_RES_CODE;
                state_next = S_EMIT;
            end
            S_DEC_RD2:
            begin
                op         = OP_DEC_RD2;
                state_next = S_DEC_CHK;
            end
            S_DEC_CHK:
            begin
                if (st.info_leaf)
                begin
                    op         = OP_DEC_LEAF;
                    state_next = S_EMIT;
                end
                else
                begin
                    op         = OP_DEC_STEP;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_B_CLR:
            begin
                op = OP_CLR_CODE;
                if (st.idx_last)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (st.cnt_use)
                begin
                    op         = OP_LEAF;
                    merge_next = 1'b0;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_SCAN_NXT;
                end
            end
            S_SCAN_NXT:
            begin
                if (st.idx_last)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    op         = OP_SCAN_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_END:
            begin
                if (st.used_zero)
                begin
                    op         = OP_BUILD_EMPTY;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_M_START;
                end
            end
            S_INS_RD:
            begin
                if (st.cur_nil)
                begin
                    state_next = S_LINK1;
                end
                else
                begin
                    op         = OP_INS_RD;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (st.wgt_lt)
                begin
                    op         = OP_INS_STEP;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_LINK1;
                end
            end
            S_LINK1:
            begin
                op         = OP_LINK1;
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                op         = OP_LINK2;
                state_next = merge_reg ? S_M_START : S_SCAN_NXT;
            end
            S_M_START:
            begin
                op         = OP_M_START;
                state_next = S_M_B;
            end
            S_M_B:
            begin
                if (st.nxt_nil)
                begin
                    state_next = S_A_INIT;
                end
                else
                begin
                    op         = OP_M_B;
                    state_next = S_M_SUM;
                end
            end
            S_M_SUM:
            begin
                op         = OP_M_SUM;
                merge_next = 1'b1;
                state_next = S_INS_RD;
            end
            S_A_INIT:
            begin
                op         = OP_A_INIT;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                op         = OP_A_RD;
                state_next = S_A_PROC;
            end
            S_A_PROC:
            begin
                if (st.info_leaf)
                begin
                    op         = OP_A_LEAF;
                    state_next = S_A_NEXT;
                end
                else
                begin
                    op         = OP_A_LEFT;
                    state_next = S_A_RIGHT;
                end
            end
            S_A_RIGHT:
            begin
                op         = OP_A_RIGHT;
                state_next = S_A_NEXT;
            end
            S_A_NEXT:
            begin
                if (st.used_zero)
                begin
                    op         = OP_A_DONE;
                    state_next = S_EMIT;
                end
                else
                begin
                    op         = OP_A_DEC;
                    state_next = S_A_RD;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

[rtl/hcb_datapath.sv]
`timescale 1ns / 1ps
module hcb_datapath #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int COUNT_BITS    = 24,
    parameter int MAX_CODE_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcb_pkg::hcb_op_t              op,
    output hcb_pkg::hcb_stat_t            st,
    input  logic [hcb_pkg::KIND_W-1:0]    in_kind,
    input  logic [hcb_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_bit,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [hcb_pkg::STATUS_W-1:0]  out_status,
    output logic [hcb_pkg::BYTE_W-1:0]    out_symbol,
    output logic                          out_symbol_valid,
    output logic [hcb_pkg::WORD_W-1:0]    out_word,
    output logic [hcb_pkg::LEN_W-1:0]     out_len
);
    import hcb_pkg::*;

    localparam int SYM_W      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int NODE_COUNT = 2 * SYMBOL_COUNT - 1;
    localparam int NODE_W     = $clog2(2 * SYMBOL_COUNT);
    localparam int INFO_W     = 2 * NODE_W + BYTE_W + 1;
    localparam int PATH_W     = LEN_W + WORD_W;
    localparam logic [NODE_W-1:0] NIL = NODE_W'(NODE_COUNT);

    // control registers
    logic [SYM_W-1:0]    idx_reg, idx_next;
    logic [NODE_W-1:0]   used_reg, used_next;
    logic [NODE_W-1:0]   head_reg, head_next;
    logic [NODE_W-1:0]   root_reg, root_next;
    logic [NODE_W-1:0]   pos_reg, pos_next;
    logic                built_reg, built_next;
    logic                root_leaf_reg, root_leaf_next;
    logic                out_valid_reg, out_valid_next;
    // working registers
    logic [NODE_W-1:0]   prev_reg, prev_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   nd_reg, nd_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   nx_reg, nx_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [WEIGHT_W-1:0] wa_reg, wa_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                bit_reg, bit_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BYTE_W-1:0]   res_sym_reg, res_sym_next;
    logic                res_sv_reg, res_sv_next;
    logic [PATH_W-1:0]   res_code_reg, res_code_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [BYTE_W-1:0]   o_sym_reg, o_sym_next;
    logic                o_sv_reg, o_sv_next;
    logic [PATH_W-1:0]   o_code_reg, o_code_next;

    // memory ports
    logic                  cnt_we, cnt_re;
    logic [SYM_W-1:0]      cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
    logic                  code_we, code_re;
    logic [SYM_W-1:0]      code_waddr;
    logic [PATH_W-1:0]     code_wdata, code_rd;
    logic                  wgt_we, node_re;
    logic [NODE_W-1:0]     node_waddr, node_raddr;
    logic [WEIGHT_W-1:0]   wgt_wdata, wgt_rd;
    logic                  nxt_we;
    logic [NODE_W-1:0]     nxt_waddr, nxt_wdata, nxt_rd;
    logic                  info_re;
    logic [NODE_W-1:0]     info_raddr;
    logic [INFO_W-1:0]     info_wdata, info_rd;
    logic                  path_we, path_re;
    logic [NODE_W-1:0]     path_waddr;
    logic [PATH_W-1:0]     path_wdata, path_rd;

    logic [NODE_W-1:0]   info_left, info_right, child;
    logic [BYTE_W-1:0]   info_sym;
    logic                info_leaf;
    logic [LEN_W-1:0]    p_len;
    logic [WORD_W-1:0]   p_bits;
    logic [PATH_W-1:0]   child0, child1;
    logic [WEIGHT_W:0]   sum_full;
    logic [WEIGHT_W-1:0] sum_sat;
    logic [SYM_W-1:0]    idx_step, byte_addr;
    logic                byte_ok;

    assign info_left  = info_rd[INFO_W-1 -: NODE_W];
    assign info_right = info_rd[NODE_W+BYTE_W -: NODE_W];
    assign info_sym   = info_rd[BYTE_W:1];
    assign info_leaf  = info_rd[0];
    assign child      = bit_reg ? info_right : info_left;

    assign p_len  = path_rd[PATH_W-1 -: LEN_W];
    assign p_bits = path_rd[WORD_W-1:0];

    always_comb
    begin
        if (p_len >= LEN_W'(MAX_CODE_BITS))
        begin
            child0 = {LEN_W'(MAX_CODE_BITS + 1), {WORD_W{1'b0}}};
            child1 = {LEN_W'(MAX_CODE_BITS + 1), {WORD_W{1'b0}}};
        end
        else
        begin
            child0 = {p_len + 1'b1, p_bits};
            child1 = {p_len + 1'b1, p_bits | (WORD_W'(1) << p_len)};
        end
    end

    assign sum_full  = {1'b0, wa_reg} + {1'b0, wgt_rd};
    assign sum_sat   = sum_full[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum_full[WEIGHT_W-1:0];
    assign idx_step  = (idx_reg == SYM_W'(SYMBOL_COUNT - 1)) ? '0 : idx_reg + 1'b1;
    assign byte_addr = byte_reg[SYM_W-1:0];
    assign byte_ok   = ({1'b0, byte_reg} < (BYTE_W + 1)'(SYMBOL_COUNT))
                       && (byte_reg != NEWLINE_BYTE);

    // status to controller
    assign st.kind      = kind_reg;
    assign st.byte_ok   = byte_ok;
    assign st.built     = built_reg;
    assign st.root_leaf = root_leaf_reg;
    assign st.idx_last  = (idx_reg == SYM_W'(SYMBOL_COUNT - 1));
    assign st.cnt_use   = (BYTE_W'(idx_reg) != NEWLINE_BYTE) && (cnt_rd != '0);
    assign st.cur_nil   = (cur_reg == NIL);
    assign st.nxt_nil   = (nxt_rd == NIL);
    assign st.wgt_lt    = (wgt_rd < w_reg);
    assign st.used_zero = (used_reg == '0);
    assign st.info_leaf = info_leaf;
    assign st.out_free  = !out_valid_reg || out_ready;

    // memory control
    always_comb
    begin
        cnt_we     = (op == OP_CLR_CNT) || (op == OP_CNT_WR);
        cnt_waddr  = (op == OP_CNT_WR) ? byte_addr : idx_reg;
        cnt_wdata  = '0;
        if (op == OP_CNT_WR)
        begin
            cnt_wdata = (cnt_rd == {COUNT_BITS{1'b1}}) ? cnt_rd : cnt_rd + 1'b1;
        end
        cnt_re     = (op == OP_CNT_RD) || (op == OP_SCAN_RD);
        cnt_raddr  = (op == OP_CNT_RD) ? byte_addr : idx_reg;

        code_we    = (op == OP_CLR_CODE)
                     || ((op == OP_A_LEAF) && (p_len <= LEN_W'(MAX_CODE_BITS)));
        code_waddr = (op == OP_CLR_CODE) ? idx_reg : info_sym[SYM_W-1:0];
        code_wdata = (op == OP_CLR_CODE) ? '0 : path_rd;
        code_re    = (op == OP_ENC_RD);

        wgt_we     = (op == OP_LEAF) || (op == OP_M_SUM);
        node_waddr = used_reg;
        wgt_wdata  = (op == OP_LEAF) ? WEIGHT_W'(cnt_rd) : sum_sat;
        info_wdata = (op == OP_LEAF) ? {NIL, NIL, BYTE_W'(idx_reg), 1'b1}
                                     : {a_reg, cur_reg, {BYTE_W{1'b0}}, 1'b0};

        node_re    = (op == OP_INS_RD) || (op == OP_M_START) || (op == OP_M_B);
        case (op)
            OP_M_START: node_raddr = head_reg;
            OP_M_B:     node_raddr = nxt_rd;
            default:    node_raddr = cur_reg;
        endcase

        nxt_we     = (op == OP_LINK1) || ((op == OP_LINK2) && (prev_reg != NIL));
        nxt_waddr  = (op == OP_LINK1) ? nd_reg : prev_reg;
        nxt_wdata  = (op == OP_LINK1) ? cur_reg : nd_reg;

        info_re    = (op == OP_DEC_RD1) || (op == OP_DEC_RD2) || (op == OP_A_RD);
        case (op)
            OP_DEC_RD1: info_raddr = pos_reg;
            OP_DEC_RD2: info_raddr = child;
            default:    info_raddr = used_reg;
        endcase

        path_we    = (op == OP_A_INIT) || (op == OP_A_LEFT) || (op == OP_A_RIGHT);
        path_re    = (op == OP_A_RD);
        case (op)
            OP_A_LEFT:
            begin
                path_waddr = info_left;
                path_wdata = child0;
            end
            OP_A_RIGHT:
            begin
                path_waddr = info_right;
                path_wdata = child1;
            end
            default:
            begin
                path_waddr = used_reg - 1'b1;
                path_wdata = '0;
            end
        endcase
    end

    hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOL_COUNT)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rd)
    );

    hcb_ram #(.WIDTH(PATH_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
        .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
        .re(code_re), .raddr(byte_addr), .rdata(code_rd)
    );

    hcb_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODE_COUNT)) u_wgt_ram (
        .clk(clk), .we(wgt_we), .waddr(node_waddr), .wdata(wgt_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(wgt_rd)
    );

    hcb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_nxt_ram (
        .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(nxt_rd)
    );

    hcb_ram #(.WIDTH(INFO_W), .DEPTH(NODE_COUNT)) u_info_ram (
        .clk(clk), .we(wgt_we), .waddr(node_waddr), .wdata(info_wdata),
        .re(info_re), .raddr(info_raddr), .rdata(info_rd)
    );

    hcb_ram #(.WIDTH(PATH_W), .DEPTH(NODE_COUNT)) u_path_ram (
        .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
        .re(path_re), .raddr(used_reg), .rdata(path_rd)
    );

    always_comb
    begin
        idx_next        = idx_reg;
        used_next       = used_reg;
        head_next       = head_reg;
        root_next       = root_reg;
        pos_next        = pos_reg;
        built_next      = built_reg;
        root_leaf_next  = root_leaf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        nd_next         = nd_reg;
        a_next          = a_reg;
        nx_next         = nx_reg;
        w_next          = w_reg;
        wa_next         = wa_reg;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_sym_next    = res_sym_reg;
        res_sv_next     = res_sv_reg;
        res_code_next   = res_code_reg;
        o_status_next   = o_status_reg;
        o_sym_next      = o_sym_reg;
        o_sv_next       = o_sv_reg;
        o_code_next     = o_code_reg;
        unique case (op)
            OP_CLR_CNT, OP_SCAN_INC:
            begin
                idx_next = idx_step;
            end
            OP_ACCEPT:
            begin
                kind_next = in_kind;
                byte_next = in_byte;
                bit_next  = in_bit;
                idx_next  = '0;
            end
            OP_RES_CODE:
            begin
                res_status_next = ST_OK;
                res_sym_next    = '0;
                res_sv_next     = 1'b0;
                res_code_next   = code_rd;
            end
            OP_RES_ST0, OP_A_DONE, OP_RES_ST2, OP_BUILD_EMPTY, OP_RES_END:
            begin
                res_sym_next  = '0;
                res_sv_next   = 1'b0;
                res_code_next = '0;
                if (op == OP_RES_ST0 || op == OP_A_DONE)
                begin
                    res_status_next = ST_OK;
                end
                else if (op == OP_RES_END)
                begin
                    res_status_next = !built_reg ? ST_NOTREE
                                    : (pos_reg != root_reg) ? ST_MIDCODE : ST_OK;
                    pos_next        = root_reg;
                end
                else
                begin
                    res_status_next = ST_NOTREE;
                end
                if (op == OP_A_DONE)
                begin
                    built_next = 1'b1;
                    pos_next   = root_reg;
                end
                if (op == OP_BUILD_EMPTY)
                begin
                    built_next = 1'b0;
                    pos_next   = '0;
                    root_next  = '0;
                end
            end
            OP_DEC_RD2:
            begin
                nx_next = child;
            end
            OP_DEC_LEAF:
            begin
                res_status_next = ST_OK;
                res_sym_next    = info_sym;
                res_sv_next     = 1'b1;
                res_code_next   = '0;
                pos_next        = root_reg;
            end
            OP_DEC_STEP:
            begin
                pos_next = nx_reg;
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                o_status_next  = res_status_reg;
                o_sym_next     = res_sym_reg;
                o_sv_next      = res_sv_reg;
                o_code_next    = res_code_reg;
            end
            OP_CLR_CODE:
            begin
                idx_next  = idx_step;
                head_next = NIL;
                used_next = '0;
            end
            OP_LEAF:
            begin
                w_next    = WEIGHT_W'(cnt_rd);
                nd_next   = used_reg;
                used_next = used_reg + 1'b1;
                prev_next = NIL;
                cur_next  = head_reg;
            end
            OP_INS_STEP:
            begin
                prev_next = cur_reg;
                cur_next  = nxt_rd;
            end
            OP_LINK2:
            begin
                if (prev_reg == NIL)
                begin
                    head_next = nd_reg;
                end
            end
            OP_M_START:
            begin
                a_next = head_reg;
            end
            OP_M_B:
            begin
                wa_next  = wgt_rd;
                cur_next = nxt_rd;
            end
            OP_M_SUM:
            begin
                // both merged nodes leave the list before the sum goes in
                head_next = nxt_rd;
                w_next    = sum_sat;
                nd_next   = used_reg;
                used_next = used_reg + 1'b1;
                prev_next = NIL;
                cur_next  = nxt_rd;
            end
            OP_A_INIT:
            begin
                root_next      = used_reg - 1'b1;
                used_next      = used_reg - 1'b1;
                root_leaf_next = (used_reg == NODE_W'(1));
            end
            OP_A_DEC:
            begin
                used_next = used_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            used_reg      <= '0;
            head_reg      <= NIL;
            root_reg      <= '0;
            pos_reg       <= '0;
            built_reg     <= 1'b0;
            root_leaf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            head_reg      <= head_next;
            root_reg      <= root_next;
            pos_reg       <= pos_next;
            built_reg     <= built_next;
            root_leaf_reg <= root_leaf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        nd_reg         <= nd_next;
        a_reg          <= a_next;
        nx_reg         <= nx_next;
        w_reg          <= w_next;
        wa_reg         <= wa_next;
        kind_reg       <= kind_next;
        byte_reg       <= byte_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_sym_reg    <= res_sym_next;
        res_sv_reg     <= res_sv_next;
        res_code_reg   <= res_code_next;
        o_status_reg   <= o_status_next;
        o_sym_reg      <= o_sym_next;
        o_sv_reg       <= o_sv_next;
        o_code_reg     <= o_code_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = o_status_reg;
    assign out_symbol       = o_sym_reg;
    assign out_symbol_valid = o_sv_reg;
    assign out_word         = o_code_reg[WORD_W-1:0];
    assign out_len          = o_code_reg[PATH_W-1 -: LEN_W];
endmodule

[rtl/huffman_codec_with_tree_build.sv]
// Static Huffman codec over a byte alphabet with on-chip tree build. After reset the
// symbol histogram is cleared over all SYMBOL_COUNT entries, during which no
// request is taken. Items are handled one at a time by a controller that sequences
// RAMs with one write and one registered read port: a count is a read-modify-write
// of the histogram RAM (skipped for an ignored byte), an encode reads the code RAM
// (not with no tree or an unencodable byte), and a decode makes two dependent node
// RAM reads (none when the root is a leaf). A build clears the code table, scans
// every byte value, makes a leaf for each counted one and merges the two lightest
// nodes in turn, with a sorted insert into a linked list through the node RAMs for
// each new node (worst case quadratic in the used symbol count), then assigns codes
// by a walk down the tree nodes. A finished result sits in an output register, so
// the next request is taken while it waits to be read.
`timescale 1ns / 1ps
module huffman_codec_with_tree_build #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int COUNT_BITS    = 24,
    parameter int MAX_CODE_BITS = 64
) (
    input logic       clk,
    input logic       rst_n,
    hcb_in_if.sink    item,
    hcb_out_if.source result
);
    import hcb_pkg::*;

    hcb_op_t   op;
    hcb_stat_t st;

    hcb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .st         (st),
        .item_ready (item.ready),
        .op         (op)
    );

    hcb_datapath #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .COUNT_BITS    (COUNT_BITS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .st               (st),
        .in_kind          (item.kind),
        .in_byte          (item.byte_value),
        .in_bit           (item.code_bit),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_status       (result.status),
        .out_symbol       (result.symbol),
        .out_symbol_valid (result.symbol_valid),
        .out_word         (result.code_word),
        .out_len          (result.code_length)
    );

`ifndef NO_ASSERTIONS
    a_accept_op: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> (op == OP_ACCEPT))
        else $error("request taken outside accept");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |=> result.valid)
        else $error("emitted result not presented");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> (!result.valid || result.ready))
        else $error("result overwritten while pending");

    a_sym_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.symbol_valid) |-> (result.status == ST_OK
            && result.code_length == '0))
        else $error("decoded symbol with bad status");
`endif
endmodule

[tb/sv/hcb_checker.sv]
`timescale 1ns / 1ps
module hcb_checker (
    input  logic clk,
    input  logic rst_n,
    hcb_in_if    req,
    hcb_out_if   rsp,
    output int   errors,
    output int   pending,
    output int   n_checked,
    output int   n_symbols,
    output int   n_builds
);
    import hcb_pkg::*;

    localparam int          NSYM     = 256;
    localparam int          NNODE    = 2 * NSYM - 1;
    localparam int          MAX_BITS = 64;
    localparam logic [23:0] CNT_MAX  = 24'hFFFFFF;
    localparam logic [8:0]  NIL      = 9'd511;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   symbol;
        logic                symbol_valid;
        logic [WORD_W-1:0]   code_word;
        logic [LEN_W-1:0]    code_length;
    } codec_out_t;

    codec_out_t awaited_out[$];

    // Mirror of the codec state; bit types so unwritten entries read as zero.
    bit [23:0]       tally[NSYM];
    bit [31:0]       wgt[NNODE];
    bit [8:0]        lft[NNODE];
    bit [8:0]        rgt[NNODE];
    bit [8:0]        nxt[NNODE];
    bit [7:0]        sym[NNODE];
    bit              leaf[NNODE];
    bit [8:0]        head;
    bit [8:0]        root;
    bit [8:0]        pos;
    bit [WORD_W-1:0] cbits[NSYM];
    bit [LEN_W-1:0]  clen[NSYM];
    bit              built;

    function automatic void link_by_weight(bit [8:0] nd);
        bit [8:0] prev;
        bit [8:0] cur;
        prev = NIL;
        cur  = head;
        // ahead of equal weights: stop at the first node not lighter
        while (cur != NIL && wgt[cur] < wgt[nd])
        begin
            prev = cur;
            cur  = nxt[cur];
        end
        nxt[nd] = cur;
        if (prev == NIL)
            head = nd;
        else
            nxt[prev] = nd;
    endfunction

    function automatic bit grow_tree();
        int              used;
        bit [8:0]        a;
        bit [8:0]        b;
        bit [8:0]        c;
        bit [32:0]       sum;
        bit [WORD_W-1:0] pbits[NNODE];
        int              plen[NNODE];
        used = 0;
        head = NIL;
        for (int s = 0; s < NSYM; s++)
        begin
            clen[s]  = '0;
            cbits[s] = '0;
        end
        for (int s = 0; s < NSYM; s++)
        begin
            if (s == NEWLINE_BYTE || tally[s] == 0)
                continue;
            wgt[used]  = 32'(tally[s]);
            lft[used]  = NIL;
            rgt[used]  = NIL;
            sym[used]  = s[7:0];
            leaf[used] = 1'b1;
            link_by_weight(used[8:0]);
            used++;
        end
        pos  = '0;
        root = '0;
        if (used == 0)
        begin
            built = 1'b0;
            return 1'b0;
        end
        while (head != NIL && nxt[head] != NIL && used < NNODE)
        begin
            a    = head;
            b    = nxt[a];
            sum  = {1'b0, wgt[a]} + {1'b0, wgt[b]};
            head = nxt[b];
            wgt[used]  = sum[32] ? 32'hFFFFFFFF : sum[31:0];
            lft[used]  = a;
            rgt[used]  = b;
            sym[used]  = '0;
            leaf[used] = 1'b0;
            link_by_weight(used[8:0]);
            used++;
        end
        root        = 9'(used - 1);
        pbits[root] = '0;
        plen[root]  = 0;
        // children sit below their parent, so a downward sweep sees parents first
        for (int i = used - 1; i >= 0; i--)
        begin
            if (leaf[i])
            begin
                if (plen[i] <= MAX_BITS)
                begin
                    clen[sym[i]]  = LEN_W'(plen[i]);
                    cbits[sym[i]] = pbits[i];
                end
                continue;
            end
            for (int k = 0; k < 2; k++)
            begin
                c = k ? rgt[i] : lft[i];
                if (c == NIL)
                    continue;
                if (plen[i] >= MAX_BITS)
                begin
                    plen[c]  = MAX_BITS + 1;
                    pbits[c] = '0;
                end
                else
                begin
                    pbits[c] = pbits[i] | (64'(k) << plen[i]);
                    plen[c]  = plen[i] + 1;
                end
            end
        end
        pos   = root;
        built = 1'b1;
        return 1'b1;
    endfunction

    function automatic void predict_request(logic [KIND_W-1:0] kind, logic [7:0] byt,
                                            logic bitv);
        codec_out_t o;
        bit [8:0]   nx;
        o = '0;
        case (kind)
            KIND_COUNT:
            begin
                if (byt != NEWLINE_BYTE && tally[byt] != CNT_MAX)
                    tally[byt]++;
            end
            KIND_BUILD:
            begin
                o.status = grow_tree() ? ST_OK : ST_NOTREE;
                awaited_out.push_back(o);
            end
            KIND_ENCODE:
            begin
                if (!built)
                    o.status = ST_NOTREE;
                else if (byt != NEWLINE_BYTE)
                begin
                    o.code_word   = cbits[byt];
                    o.code_length = clen[byt];
                end
                awaited_out.push_back(o);
            end
            KIND_DECODE:
            begin
                if (!built)
                begin
                    o.status = ST_NOTREE;
                    awaited_out.push_back(o);
                end
                else if (!leaf[root])
                begin
                    if (leaf[pos])
                        pos = root;
                    nx = bitv ? rgt[pos] : lft[pos];
                    if (nx == NIL)
                        pos = root;
                    else if (leaf[nx])
                    begin
                        o.symbol       = sym[nx];
                        o.symbol_valid = 1'b1;
                        pos            = root;
                        awaited_out.push_back(o);
                    end
                    else
                        pos = nx;
                end
            end
            KIND_END:
            begin
                if (!built)
                    o.status = ST_NOTREE;
                else if (pos != root)
                    o.status = ST_MIDCODE;
                pos = root;
                awaited_out.push_back(o);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        codec_out_t e;
        if (!rst_n)
        begin
            awaited_out.delete();
            for (int s = 0; s < NSYM; s++)
            begin
                tally[s] = '0;
                clen[s]  = '0;
                cbits[s] = '0;
            end
            head      = NIL;
            root      = '0;
            pos       = '0;
            built     = 1'b0;
            errors    = 0;
            pending   = 0;
            n_checked = 0;
            n_symbols = 0;
            n_builds  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_out.size() == 0)
                begin
                    $error("result with nothing awaited");
                    errors++;
                end
                else
                begin
                    e = awaited_out.pop_front();
                    check_field("status", e.status, rsp.status);
                    check_field("symbol", e.symbol, rsp.symbol);
                    check_field("symbol_valid", e.symbol_valid, rsp.symbol_valid);
                    check_field("code_word", e.code_word, rsp.code_word);
                    check_field("code_length", e.code_length, rsp.code_length);
                    n_checked++;
                    if (e.symbol_valid)
                        n_symbols++;
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.kind == KIND_BUILD)
                    n_builds++;
                predict_request(req.kind, req.byte_value, req.code_bit);
            end
            pending = awaited_out.size();
        end
    end
endmodule

[tb/sv/tb_huffman_codec_with_tree_build.sv]
`timescale 1ns / 1ps
module tb_huffman_codec_with_tree_build;
    import hcb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int                IDLE_LIMIT    = 1000000;
    localparam int                N_ITEMS       = 1000;
    // rough size of the closing wide-alphabet session
    localparam int                WIDE_ITEMS    = 290;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   n_checked;
    int   n_symbols;
    int   n_builds;
    int   n_sent;
    int   idle_pct;
    int   stall_pct;
    int   quiet;

    hcb_in_if  req_if ();
    hcb_out_if rsp_if ();

    huffman_codec_with_tree_build i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_if.sink),
        .result (rsp_if.source)
    );

    hcb_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .errors    (errors),
        .pending   (pending),
        .n_checked (n_checked),
        .n_symbols (n_symbols),
        .n_builds  (n_builds)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(negedge clk)
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog: cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet <= 0;
        else if (quiet >= IDLE_LIMIT)
        begin
            $display("huffman_codec_with_tree_build regression: fail");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic push(logic [KIND_W-1:0] kind, logic [7:0] byt, logic bitv);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.byte_value <= byt;
        req_if.code_bit   <= bitv;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        n_sent++;
    endtask

    // mostly a narrow alphabet so trees stay cheap to build; edges of the byte mixed in
    function automatic logic [7:0] pick_byte(bit wide);
        int r;
        r = $urandom_range(0, 99);
        if (wide || r < 5)
            return 8'($urandom_range(0, 255));
        if (r < 10)
            return NEWLINE_BYTE;
        if (r < 14)
            return 8'hFF;
        if (r < 18)
            return 8'h80;
        return 8'($urandom_range(0, 15));
    endfunction

    task automatic run_session(bit wide);
        int r;
        int n;
        n = wide ? 250 : $urandom_range(3, 30);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                push(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 8'($urandom),
                     1'($urandom));
            else
                push(KIND_COUNT, pick_byte(wide), 1'($urandom));
        end
        push(KIND_BUILD, 8'($urandom), 1'($urandom));
        n = $urandom_range(20, 50);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                push(KIND_DECODE, 8'($urandom), 1'($urandom_range(0, 1)));
            else if (r < 88)
                push(KIND_ENCODE, pick_byte(wide), 1'($urandom));
            else if (r < 94)
                push(KIND_END, 8'($urandom), 1'($urandom));
            else if (r < 97)
                push(KIND_COUNT, pick_byte(wide), 1'($urandom));
            else
                push(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 8'($urandom),
                     1'($urandom));
        end
    endtask

    initial
    begin
        int session;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_COUNT;
        req_if.byte_value = '0;
        req_if.code_bit   = 1'b0;
        rsp_if.ready      = 1'b0;
        rst_n             = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        quiet             = 0;
        n_sent            = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing built yet: every answering request reports no tree
        push(KIND_ENCODE, 8'h41, 1'b0);
        push(KIND_DECODE, 8'h00, 1'b1);
        push(KIND_END, 8'h00, 1'b0);
        push(KIND_COUNT, NEWLINE_BYTE, 1'b0);
        push(KIND_BUILD, 8'h00, 1'b0);
        // lone symbol: empty code, decode bits vanish
        push(KIND_COUNT, 8'h41, 1'b0);
        push(KIND_BUILD, 8'h00, 1'b0);
        push(KIND_ENCODE, 8'h41, 1'b0);
        push(KIND_DECODE, 8'h00, 1'b1);
        push(KIND_END, 8'h00, 1'b0);
        push(KIND_SPARE_HI, 8'hFF, 1'b1);
        // byte extremes, equal weights and an end after whole codes
        push(KIND_COUNT, 8'h00, 1'b0);
        push(KIND_COUNT, 8'hFF, 1'b1);
        push(KIND_COUNT, 8'h00, 1'b0);
        push(KIND_BUILD, 8'h00, 1'b0);
        push(KIND_ENCODE, 8'h00, 1'b0);
        push(KIND_ENCODE, 8'hFF, 1'b0);
        push(KIND_ENCODE, NEWLINE_BYTE, 1'b0);
        push(KIND_ENCODE, 8'h7E, 1'b0);
        push(KIND_DECODE, 8'h00, 1'b1);
        push(KIND_DECODE, 8'h00, 1'b0);
        push(KIND_DECODE, 8'h00, 1'b1);
        push(KIND_END, 8'h00, 1'b0);
        push(KIND_SPARE_LO, 8'h00, 1'b0);

        session = 0;
        while (n_sent < N_ITEMS - WIDE_ITEMS)
        begin
            case (session % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 60;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 60;
                end
                default:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            run_session(1'b0);
            session++;
        end
        // one wide-alphabet pass last, since counts never clear and big builds are slow
        idle_pct  = 6;
        stall_pct = 6;
        run_session(1'b1);

        @(negedge clk);
        req_if.valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("covered %0d requests over %0d sessions, %0d tree builds", n_sent,
                 session + 1, n_builds);
        $display("checked %0d results, %0d of them decoded symbols", n_checked, n_symbols);
        if (errors == 0)
            $display("huffman_codec_with_tree_build regression: pass");
        else
            $display("huffman_codec_with_tree_build regression: fail");
        $finish;
    end
endmodule

[filelist.f]
rtl/hcb_pkg.sv
rtl/hcb_in_if.sv
rtl/hcb_out_if.sv
rtl/hcb_ram.sv
rtl/hcb_ctrl.sv
rtl/hcb_datapath.sv
rtl/huffman_codec_with_tree_build.sv
tb/sv/hcb_checker.sv
tb/sv/tb_huffman_codec_with_tree_build.sv
